>>> design/seven_segment_text_line_assert.svh
// Assertion macros shared by the seven-segment text line modules.
// Each macro expects clk and arst_n in the scope of the module that uses it.
`ifndef SEVEN_SEGMENT_TEXT_LINE_ASSERT_SVH
`define SEVEN_SEGMENT_TEXT_LINE_ASSERT_SVH

// Check that a condition implies a consequence in the same cycle.
`define SSTL_ASSERT_NOW(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("%m: same-cycle check failed");

// Check that a condition implies a consequence in the next cycle.
`define SSTL_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("%m: next-cycle check failed");

`endif

>>> design/sstl_pkg.sv
// Package for the seven-segment text line: command types, character codes
// and the font lookup. No dependencies.
package sstl_pkg;

	// character codes with a meaning of their own
	localparam logic [7:0] CHAR_NEWLINE = 8'h0A;
	localparam logic [7:0] CHAR_RETURN  = 8'h0D;
	localparam logic [7:0] CHAR_DOT     = 8'h2E;

	// glyphs
	localparam logic [7:0] GLYPH_BLANK = 8'h00;
	localparam logic [7:0] GLYPH_DOT   = 8'h01;

	// depth of the queue between front and back
	localparam int unsigned QUEUE_DEPTH = 2;

	typedef enum logic [1:0] {
		OP_GLYPH,
		OP_DOT,
		OP_NEWLINE,
		OP_RETURN
	} op_t;

	// one classified item as it travels from front to back
	typedef struct packed {
		op_t        op;
		logic [7:0] glyph;
	} cmd_t;

	// font lookup; characters outside space to '9' give a blank
	function automatic logic [7:0] font_glyph(input logic [7:0] ch);
		logic [7:0] g;
		case (ch)
			8'h28:   g = 8'h9c; // '('
			8'h29:   g = 8'hf0; // ')'
			8'h2D:   g = 8'h02; // '-'
			8'h2E:   g = 8'h01; // '.'
			8'h2F:   g = 8'h4a; // '/'
			8'h30:   g = 8'hfc;
			8'h31:   g = 8'h60;
			8'h32:   g = 8'hda;
			8'h33:   g = 8'hf2;
			8'h34:   g = 8'h66;
			8'h35:   g = 8'hb6;
			8'h36:   g = 8'hbe;
			8'h37:   g = 8'he0;
			8'h38:   g = 8'hfe;
			8'h39:   g = 8'hf6;
			default: g = GLYPH_BLANK;
		endcase
		return g;
	endfunction

endpackage

>>> design/sstl_front.sv
// Front of the seven-segment text line: accepts characters, classifies them
// and looks up their glyph. Depends on sstl_pkg.
module sstl_front (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_stall,
	input  logic [7:0]          char_code,
	output logic                push,
	output sstl_pkg::cmd_t      push_cmd,
	input  logic                q_full
);

	logic           valid_s1;
	sstl_pkg::cmd_t cmd_s1;
	sstl_pkg::cmd_t cmd_class;
	logic           accept;

	// hold the stage while the queue is full
	assign in_stall = valid_s1 & q_full;
	assign accept   = in_valid & ~in_stall;
	assign push     = valid_s1 & ~q_full;
	assign push_cmd = cmd_s1;

	// classify the character
	always_comb begin
		cmd_class.glyph = sstl_pkg::font_glyph(char_code);
		case (char_code)
			sstl_pkg::CHAR_NEWLINE: cmd_class.op = sstl_pkg::OP_NEWLINE;
			sstl_pkg::CHAR_RETURN:  cmd_class.op = sstl_pkg::OP_RETURN;
			sstl_pkg::CHAR_DOT:     cmd_class.op = sstl_pkg::OP_DOT;
			default:                cmd_class.op = sstl_pkg::OP_GLYPH;
		endcase
	end

	// advance the stage valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= accept | in_stall;
		end
	end

	// load the classified item
	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_s1 <= cmd_class;
		end
	end

endmodule

>>> design/sstl_queue.sv
// Short queue of classified items between front and back of the
// seven-segment text line. Depends on sstl_pkg.
`include "seven_segment_text_line_assert.svh"

module sstl_queue (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  sstl_pkg::cmd_t push_cmd,
	output logic           full,
	input  logic           pop,
	output logic           head_valid,
	output sstl_pkg::cmd_t head_cmd
);

	localparam int unsigned DEPTH = sstl_pkg::QUEUE_DEPTH;
	localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CNT_W = $clog2(DEPTH + 1);

	sstl_pkg::cmd_t     entry_q [DEPTH];
	logic [PTR_W-1:0]   wr_ptr_q;
	logic [PTR_W-1:0]   rd_ptr_q;
	logic [CNT_W-1:0]   count_q;

	assign full       = (count_q == CNT_W'(DEPTH));
	assign head_valid = (count_q != '0);
	assign head_cmd   = entry_q[rd_ptr_q];

	// advance pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	// store the pushed item
	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_cmd;
		end
	end

	`SSTL_ASSERT_NOW(a_no_push_full, full, !push)
	`SSTL_ASSERT_NOW(a_no_pop_empty, !head_valid, !pop)
	`SSTL_ASSERT_NOW(a_count_bound, 1'b1, count_q <= CNT_W'(DEPTH))

endmodule

>>> design/sstl_back.sv
// Back of the seven-segment text line: applies classified items to the digit
// line and cursor and holds the result register. Depends on sstl_pkg.
`include "seven_segment_text_line_assert.svh"

module sstl_back #(
	parameter int unsigned DIGITS = 4
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           head_valid,
	input  sstl_pkg::cmd_t head_cmd,
	output logic           pop,
	output logic           out_valid,
	input  logic           out_stall,
	output logic [31:0]    segment_line,
	output logic [2:0]     write_pos,
	output logic           shift_refresh
);

	localparam int unsigned CUR_W = $clog2(DIGITS + 1);
	localparam int unsigned IDX_W = (DIGITS > 1) ? $clog2(DIGITS) : 1;
	localparam int unsigned SHOWN = (DIGITS < 4) ? DIGITS : 4;

	logic [7:0]       digit_q [DIGITS];
	logic [CUR_W-1:0] cursor_q;
	logic [7:0]       digit_n [DIGITS];
	logic [7:0]       shifted [DIGITS];
	logic [CUR_W-1:0] cursor_n;
	logic [CUR_W-1:0] cursor_m1;
	logic [7:0]       prev_digit;
	logic             line_full;
	logic             dot_ok;
	logic             refresh_n;
	logic [31:0]      line_n;
	logic             out_valid_q;
	logic [31:0]      line_q;
	logic [2:0]       pos_q;
	logic             refresh_q;

	// take the head whenever the result register is free or being taken
	assign pop = head_valid & (~out_valid_q | ~out_stall);

	assign cursor_m1  = cursor_q - 1'b1;
	assign prev_digit = digit_q[cursor_m1[IDX_W-1:0]];
	assign line_full  = (cursor_q >= CUR_W'(DIGITS));
	assign dot_ok     = (cursor_q != '0) && !prev_digit[0];

	// line shifted left with the new glyph in the last digit
	always_comb begin
		for (int i = 0; i < DIGITS - 1; i++) begin
			shifted[i] = digit_q[i + 1];
		end
		shifted[DIGITS - 1] = head_cmd.glyph;
	end

	// next line and cursor
	always_comb begin
		refresh_n = 1'b0;
		cursor_n  = cursor_q;
		for (int i = 0; i < DIGITS; i++) begin
			digit_n[i] = digit_q[i];
		end
		case (head_cmd.op)
			sstl_pkg::OP_NEWLINE: begin
				cursor_n = '0;
				for (int i = 0; i < DIGITS; i++) begin
					digit_n[i] = sstl_pkg::GLYPH_BLANK;
				end
			end
			sstl_pkg::OP_RETURN: begin
				cursor_n = '0;
			end
			sstl_pkg::OP_DOT,
			sstl_pkg::OP_GLYPH: begin
				if (head_cmd.op == sstl_pkg::OP_DOT && dot_ok) begin
					for (int i = 0; i < DIGITS; i++) begin
						if (CUR_W'(i) == cursor_m1) begin
							digit_n[i] = digit_q[i] | sstl_pkg::GLYPH_DOT;
						end
					end
				end else if (line_full) begin
					refresh_n = 1'b1;
					for (int i = 0; i < DIGITS; i++) begin
						digit_n[i] = shifted[i];
					end
				end else begin
					cursor_n = cursor_q + 1'b1;
					for (int i = 0; i < DIGITS; i++) begin
						if (CUR_W'(i) == cursor_q) begin
							digit_n[i] = head_cmd.glyph;
						end
					end
				end
			end
			default: begin
				cursor_n = cursor_q;
			end
		endcase
	end

	// pack the shown digits, digit 0 in the top byte
	always_comb begin
		line_n = '0;
		for (int i = 0; i < SHOWN; i++) begin
			line_n[31 - 8 * i -: 8] = digit_n[i];
		end
	end

	// update line state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cursor_q <= '0;
			for (int i = 0; i < DIGITS; i++) begin
				digit_q[i] <= sstl_pkg::GLYPH_BLANK;
			end
		end else if (pop) begin
			cursor_q <= cursor_n;
			for (int i = 0; i < DIGITS; i++) begin
				digit_q[i] <= digit_n[i];
			end
		end
	end

	// hold the result valid until taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (pop) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	// load the result payload
	always_ff @(posedge clk) begin
		if (pop) begin
			line_q    <= line_n;
			pos_q     <= 3'(cursor_n);
			refresh_q <= refresh_n;
		end
	end

	assign out_valid     = out_valid_q;
	assign segment_line  = line_q;
	assign write_pos     = pos_q;
	assign shift_refresh = refresh_q;

	`SSTL_ASSERT_NEXT(a_newline_blanks, pop && head_cmd.op == sstl_pkg::OP_NEWLINE,
		segment_line == '0 && write_pos == '0 && !shift_refresh)
	`SSTL_ASSERT_NEXT(a_return_rewinds, pop && head_cmd.op == sstl_pkg::OP_RETURN,
		write_pos == '0 && !shift_refresh)
	`SSTL_ASSERT_NOW(a_refresh_at_end, out_valid_q && refresh_q, pos_q == 3'(DIGITS))

endmodule

>>> design/seven_segment_text_line.sv
// Seven-segment text line: characters in, a full line of segment codes out.
// Instantiates sstl_front, sstl_queue and sstl_back; depends on sstl_pkg.
//
// Usage:
//   Input channel (in_valid, in_stall, char_code) carries one ASCII character
//   per item. Output channel (out_valid, out_stall, segment_line, write_pos,
//   shift_refresh) gives exactly one result item per character: the whole
//   line after that character (at most its first four digits), digit 0 in the top byte, the next write
//   position and the overflow refresh flag.
//   An accepted character passes the front classification register, then
//   the two-entry queue, then the back result register before its result is
//   valid. Throughput is one item per cycle while the receiver does not
//   stall; the line update in the back is the loop that sets it.
//   Reset blanks all digits, rewinds the cursor and empties the pipeline.
//   When the receiver stalls, the result register holds, the queue fills
//   behind it, and in_stall rises once the front register cannot drain.
module seven_segment_text_line #(
	parameter int unsigned DIGITS = 4
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [7:0]  char_code,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [31:0] segment_line,
	output logic [2:0]  write_pos,
	output logic        shift_refresh
);

	logic           push;
	sstl_pkg::cmd_t push_cmd;
	logic           q_full;
	logic           pop;
	logic           head_valid;
	sstl_pkg::cmd_t head_cmd;

	sstl_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.char_code (char_code),
		.push      (push),
		.push_cmd  (push_cmd),
		.q_full    (q_full)
	);

	sstl_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_cmd   (push_cmd),
		.full       (q_full),
		.pop        (pop),
		.head_valid (head_valid),
		.head_cmd   (head_cmd)
	);

	sstl_back #(
		.DIGITS (DIGITS)
	) u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.head_valid    (head_valid),
		.head_cmd      (head_cmd),
		.pop           (pop),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.segment_line  (segment_line),
		.write_pos     (write_pos),
		.shift_refresh (shift_refresh)
	);

endmodule
